FILE: hdl/qth_pkg.sv
// Shared constants and the arctangent table function for the quaternion to compass heading block.
`default_nettype none
package qth_pkg;
	localparam int MaxStages = 24;
	localparam int AngW = 34;
	localparam int TolW = 15;
	localparam int HeadW = 16;
	localparam logic [AngW-1:0] Ang90 = 34'd589824000;
	localparam logic [AngW-1:0] Ang180 = 34'd1179648000;

	function automatic logic [AngW-1:0] atan_entry(input int i);
		logic [AngW-1:0] t;
		unique case (i)
			0: t = 34'd294912000;
			1: t = 34'd174096719;
			2: t = 34'd91987925;
			3: t = 34'd46694507;
			4: t = 34'd23437865;
			5: t = 34'd11730358;
			6: t = 34'd5866610;
			7: t = 34'd2933484;
			8: t = 34'd1466764;
			9: t = 34'd733385;
			10: t = 34'd366693;
			11: t = 34'd183346;
			12: t = 34'd91673;
			13: t = 34'd45837;
			14: t = 34'd22918;
			15: t = 34'd11459;
			16: t = 34'd5730;
			17: t = 34'd2865;
			18: t = 34'd1432;
			19: t = 34'd716;
			20: t = 34'd358;
			21: t = 34'd179;
			22: t = 34'd90;
			23: t = 34'd45;
			default: t = '0;
		endcase
		return t;
	endfunction
endpackage
`default_nettype wire

FILE: hdl/qth_if.sv
// Valid/ready stream interfaces for quaternion requests and heading results.
`default_nettype none
interface qth_quat_if #(parameter int QUAT_WIDTH = 16);
	logic valid;
	logic ready;
	logic signed [QUAT_WIDTH-1:0] quat_x;
	logic signed [QUAT_WIDTH-1:0] quat_y;
	logic signed [QUAT_WIDTH-1:0] quat_z;
	logic signed [QUAT_WIDTH-1:0] quat_w;
	modport source(output valid, quat_x, quat_y, quat_z, quat_w, input ready);
	modport sink(input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

interface qth_head_if;
	logic valid;
	logic ready;
	logic [15:0] heading_centideg;
	logic heading_ok;
	modport source(output valid, heading_centideg, heading_ok, input ready);
	modport sink(input valid, heading_centideg, heading_ok, output ready);
endinterface
`default_nettype wire

FILE: hdl/qth_front.sv
// Front end: rotated forward vector, level test and normalization for CORDIC.
`default_nettype none
module qth_front #(
	parameter int QUAT_WIDTH = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic en,
	input wire logic in_valid,
	input wire logic signed [QUAT_WIDTH-1:0] qx,
	input wire logic signed [QUAT_WIDTH-1:0] qy,
	input wire logic signed [QUAT_WIDTH-1:0] qz,
	input wire logic signed [QUAT_WIDTH-1:0] qw,
	input wire logic [qth_pkg::TolW-1:0] tol,
	output logic out_valid,
	output logic [29:0] xm,
	output logic [29:0] ym,
	output logic vx_neg,
	output logic vy_neg,
	output logic level
);
	import qth_pkg::*;
	localparam int PW = 2 * QUAT_WIDTH;
	localparam int SW = PW + 2;
	localparam int SH = 2 * QUAT_WIDTH - 17;

	logic v_s1, v_s2;
	logic signed [PW-1:0] pxy_s1, pwz_s1, pww_s1, pyy_s1, pxx_s1, pzz_s1;
	logic signed [SW-1:0] hx, pos, neg;
	logic [SW-1:0] ax, my, ax2, tolx;
	logic [SW-1:0] ax2_s2, my_s2;
	logic vxn_s2, vyn_s2, lvl_s2;
	logic [6:0] lzx, lzy, lz, s;
	logic [SW-1:0] xs, ys;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			out_valid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pxy_s1 <= qx * qy;
			pwz_s1 <= qw * qz;
			pww_s1 <= qw * qw;
			pyy_s1 <= qy * qy;
			pxx_s1 <= qx * qx;
			pzz_s1 <= qz * qz;
		end
	end

	always_comb begin
		hx = SW'(pxy_s1) - SW'(pwz_s1);
		pos = SW'(pww_s1) + SW'(pyy_s1);
		neg = SW'(pxx_s1) + SW'(pzz_s1);
		ax = hx[SW-1] ? SW'(-hx) : SW'(hx);
		my = (pos < neg) ? SW'(neg - pos) : SW'(pos - neg);
		ax2 = ax << 1;
		if (SH >= 0) tolx = SW'(tol) << SH;
		else tolx = SW'(tol) >> (-SH);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax2_s2 <= ax2;
			my_s2 <= my;
			vxn_s2 <= hx[SW-1];
			vyn_s2 <= pos < neg;
			lvl_s2 <= (ax < ((tolx + 1'b1) >> 1)) && (my < tolx);
		end
	end

	always_comb begin
		lzx = 7'd0;
		lzy = 7'd0;
		for (int i = 0; i < SW; i++) begin
			if (ax2_s2[i]) lzy = 7'(i + 1);
			if (my_s2[i]) lzx = 7'(i + 1);
		end
		lz = (lzx > lzy) ? lzx : lzy;
		s = (lz > 7'd30) ? 7'(lz - 7'd30) : 7'd0;
		xs = my_s2 >> s;
		ys = ax2_s2 >> s;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xm <= xs[29:0];
			ym <= ys[29:0];
			vx_neg <= vxn_s2;
			vy_neg <= vyn_s2;
			level <= lvl_s2;
		end
	end
endmodule
`default_nettype wire

FILE: hdl/qth_cordic.sv
// Unrolled vectoring CORDIC, one iteration per pipeline stage.
`default_nettype none
module qth_cordic #(
	parameter int CORDIC_STAGES = 18
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic en,
	input wire logic in_valid,
	input wire logic [29:0] xm,
	input wire logic [29:0] ym,
	input wire logic vx_neg,
	input wire logic vy_neg,
	input wire logic level,
	output logic out_valid,
	output logic signed [qth_pkg::AngW-1:0] angle,
	output logic vx_neg_o,
	output logic vy_neg_o,
	output logic level_o,
	output logic zero_o
);
	import qth_pkg::*;
	localparam int N = CORDIC_STAGES;
	localparam int CW = 34;

	logic v_q [N+1];
	logic signed [CW-1:0] cx_q [N+1];
	logic signed [CW-1:0] cy_q [N+1];
	logic signed [AngW-1:0] z_q [N+1];
	logic xn_q [N+1];
	logic yn_q [N+1];
	logic lv_q [N+1];
	logic zr_q [N+1];

	always_comb begin
		v_q[0] = in_valid;
		cx_q[0] = CW'(xm);
		cy_q[0] = CW'(ym);
		z_q[0] = '0;
		xn_q[0] = vx_neg;
		yn_q[0] = vy_neg;
		lv_q[0] = level;
		zr_q[0] = (ym == 30'd0);
	end

	for (genvar i = 0; i < N; i++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_q[i+1] <= 1'b0;
			else if (en) v_q[i+1] <= v_q[i];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (!cy_q[i][CW-1]) begin
					cx_q[i+1] <= cx_q[i] + (cy_q[i] >>> i);
					cy_q[i+1] <= cy_q[i] - (cx_q[i] >>> i);
					z_q[i+1] <= z_q[i] + atan_entry(i);
				end else begin
					cx_q[i+1] <= cx_q[i] - (cy_q[i] >>> i);
					cy_q[i+1] <= cy_q[i] + (cx_q[i] >>> i);
					z_q[i+1] <= z_q[i] - atan_entry(i);
				end
				xn_q[i+1] <= xn_q[i];
				yn_q[i+1] <= yn_q[i];
				lv_q[i+1] <= lv_q[i];
				zr_q[i+1] <= zr_q[i];
			end
		end
	end

	assign out_valid = v_q[N];
	assign angle = z_q[N];
	assign vx_neg_o = xn_q[N];
	assign vy_neg_o = yn_q[N];
	assign level_o = lv_q[N];
	assign zero_o = zr_q[N];
endmodule
`default_nettype wire

FILE: hdl/qth_back.sv
// Back end: clamp, quadrant placement and rounding to hundredths of a degree.
`default_nettype none
module qth_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic en,
	input wire logic in_valid,
	input wire logic signed [qth_pkg::AngW-1:0] angle,
	input wire logic vx_neg,
	input wire logic vy_neg,
	input wire logic level,
	input wire logic zero,
	output logic out_valid,
	output logic [qth_pkg::HeadW-1:0] heading,
	output logic hvalid
);
	import qth_pkg::*;
	logic [AngW-1:0] base;
	logic signed [AngW:0] ang, adj;
	logic signed [AngW:0] ang_s1;
	logic lvl_s1;
	logic v_s1;
	logic signed [AngW-16:0] r;
	logic [HeadW:0] res;

	always_comb begin
		if (zero || angle < 0) base = '0;
		else if (angle > $signed(Ang90)) base = Ang90;
		else base = angle;
		if (!vy_neg) ang = vx_neg ? -$signed({1'b0, base}) : $signed({1'b0, base});
		else ang = vx_neg ? -$signed({1'b0, Ang180 - base}) : $signed({1'b0, Ang180 - base});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			out_valid <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ang_s1 <= ang;
			lvl_s1 <= level;
		end
	end

	always_comb begin
		adj = ang_s1 + (AngW+1)'(32768);
		r = adj[AngW:16];
		if (r < 0) res = (HeadW+1)'(r + 36000);
		else res = (HeadW+1)'(r);
		if (res > 17'd35999) res = 17'd35999;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			heading <= lvl_s1 ? '0 : res[HeadW-1:0];
			hvalid <= !lvl_s1;
		end
	end
endmodule
`default_nettype wire

FILE: hdl/quaternion_to_compass_heading.sv
// Top level of the quaternion to compass heading pipeline.
`default_nettype none
// Converts an orientation quaternion into a compass heading in hundredths of
// a degree. One request is taken every cycle while the result slot is free; the
// pipeline has three front-end stages, one per CORDIC iteration and two back-end
// stages. The whole pipeline advances together when the result slot is free.
// The level tolerance tol_q resets to 2856 (sin 5 deg) and is written by cfg_we.
module quaternion_to_compass_heading #(
	parameter int CORDIC_STAGES = 18,
	parameter int QUAT_WIDTH = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [qth_pkg::TolW-1:0] cfg_wdata,
	qth_quat_if.sink quat,
	qth_head_if.source head
);
	import qth_pkg::*;
	logic [TolW-1:0] tol_q;
	logic en;
	logic fv, fxn, fyn, flv;
	logic [29:0] fxm, fym;
	logic cv, cxn, cyn, clv, czr;
	logic signed [AngW-1:0] cang;
	logic bv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) tol_q <= TolW'(2856);
		else if (cfg_we) tol_q <= cfg_wdata;
	end

	assign en = !head.valid || head.ready;
	assign quat.ready = en;
	assign head.valid = bv;

	qth_front #(.QUAT_WIDTH(QUAT_WIDTH)) u_front (
		.clk, .arst_n, .en, .in_valid(quat.valid),
		.qx(quat.quat_x), .qy(quat.quat_y), .qz(quat.quat_z), .qw(quat.quat_w),
		.tol(tol_q), .out_valid(fv), .xm(fxm), .ym(fym),
		.vx_neg(fxn), .vy_neg(fyn), .level(flv)
	);

	qth_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic (
		.clk, .arst_n, .en, .in_valid(fv), .xm(fxm), .ym(fym),
		.vx_neg(fxn), .vy_neg(fyn), .level(flv),
		.out_valid(cv), .angle(cang), .vx_neg_o(cxn), .vy_neg_o(cyn),
		.level_o(clv), .zero_o(czr)
	);

	qth_back u_back (
		.clk, .arst_n, .en, .in_valid(cv), .angle(cang),
		.vx_neg(cxn), .vy_neg(cyn), .level(clv), .zero(czr),
		.out_valid(bv), .heading(head.heading_centideg), .hvalid(head.heading_ok)
	);
endmodule
`default_nettype wire

FILE: test/quaternion_to_compass_heading_tb.sv
// Self-checking testbench for the quaternion to compass heading block.
`default_nettype none
class heading_scoreboard;
	typedef struct packed {
		logic [15:0] centideg;
		logic ok;
	} heading_t;

	heading_t pending[$];
	int errors;
	logic [14:0] tolerance;

	function new();
		pending = {};
		errors = 0;
		tolerance = 15'd2856;
	endfunction

	static function longint first_quadrant(longint xm, longint ym);
		longint cx, cy, z, nx, ny;
		longint tab[24] = '{294912000, 174096719, 91987925, 46694507, 23437865, 11730358,
			5866610, 2933484, 1466764, 733385, 366693, 183346, 91673, 45837, 22918,
			11459, 5730, 2865, 1432, 716, 358, 179, 90, 45};
		cx = xm;
		cy = ym;
		z = 0;
		if (ym == 0) return 0;
		for (int i = 0; i < 18; i++) begin
			if (cy >= 0) begin
				nx = cx + (cy >>> i);
				ny = cy - (cx >>> i);
				z += tab[i];
			end else begin
				nx = cx - (cy >>> i);
				ny = cy + (cx >>> i);
				z -= tab[i];
			end
			cx = nx;
			cy = ny;
		end
		if (z < 0) z = 0;
		if (z > 64'd589824000) z = 589824000;
		return z;
	endfunction

	function void note_request(logic signed [15:0] qx, logic signed [15:0] qy,
			logic signed [15:0] qz, logic signed [15:0] qw);
		longint hx, pos, neg, ax, my, tol, base, ang, r, xm, ym, yc, xc;
		bit vx_neg, vy_neg;
		int s;
		heading_t h;
		hx = longint'(qx) * qy - longint'(qw) * qz;
		pos = longint'(qw) * qw + longint'(qy) * qy;
		neg = longint'(qx) * qx + longint'(qz) * qz;
		vx_neg = hx < 0;
		vy_neg = pos < neg;
		ax = vx_neg ? -hx : hx;
		my = vy_neg ? neg - pos : pos - neg;
		tol = longint'(tolerance) << 15;
		if (ax < ((tol + 1) >> 1) && my < tol) begin
			h.centideg = 0;
			h.ok = 0;
		end else begin
			s = 0;
			forever begin
				yc = (s == 0) ? (ax << 1) : (ax >> (s - 1));
				xc = my >> s;
				if (yc < (64'd1 << 30) && xc < (64'd1 << 30)) break;
				s++;
			end
			xm = xc;
			ym = yc;
			base = first_quadrant(xm, ym);
			if (!vy_neg) ang = vx_neg ? -base : base;
			else ang = vx_neg ? -(64'd1179648000 - base) : (64'd1179648000 - base);
			r = ((ang + 32768 + 64'd36000 * 65536) / 65536) - 36000;
			if (r < 0) r += 36000;
			if (r > 35999) r = 35999;
			h.centideg = r[15:0];
			h.ok = 1;
		end
		pending.push_back(h);
	endfunction

	task check_result(logic [15:0] centideg, logic ok);
		heading_t h;
		if (pending.size() == 0) begin
			report("unexpected heading", 0, centideg);
			return;
		end
		h = pending.pop_front();
		if (ok !== h.ok) report("heading_ok", h.ok, ok);
		if (centideg !== h.centideg) report("heading_centideg", h.centideg, centideg);
	endtask

	task report(string what, int want, int got);
		$display("mismatch %s: expected %0d got %0d", what, want, got);
		errors++;
	endtask
endclass

module quaternion_to_compass_heading_tb;
	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [14:0] cfg_wdata;
	int cycles;
	int stall_phase;
	heading_scoreboard board;

	qth_quat_if #(.QUAT_WIDTH(16)) quat();
	qth_head_if head();

	quaternion_to_compass_heading DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.quat(quat.sink),
		.head(head.source)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("TB_ERROR");
			$finish;
		end
		if (head.valid && head.ready)
			board.check_result(head.heading_centideg, head.heading_ok);
		if (quat.valid && quat.ready)
			board.note_request(quat.quat_x, quat.quat_y, quat.quat_z, quat.quat_w);
	end

	// stall the result side in a rotating pattern with calm stretches
	always @(negedge clk) begin
		if (!arst_n) begin
			head.ready <= 1;
		end else begin
			stall_phase <= stall_phase + 1;
			if (stall_phase % 600 < 200) head.ready <= 1;
			else if (stall_phase % 600 < 400) head.ready <= (stall_phase % 7) != 3;
			else head.ready <= $urandom_range(0, 2) != 0;
		end
	end

	task automatic send_request(logic [15:0] x, logic [15:0] y, logic [15:0] z,
			logic [15:0] w);
		quat.quat_x <= x;
		quat.quat_y <= y;
		quat.quat_z <= z;
		quat.quat_w <= w;
		quat.valid <= 1;
		@(posedge clk);
		while (!quat.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic hold_off();
		quat.valid <= 0;
		@(negedge clk);
	endtask

	task automatic drain();
		quat.valid <= 0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	task automatic write_tolerance(logic [14:0] v);
		cfg_we <= 1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 0;
		board.tolerance = v;
		@(negedge clk);
	endtask

	task automatic random_phase(int n);
		int burst;
		logic [15:0] c [4];
		while (n > 0) begin
			burst = $urandom_range(1, 20);
			while (burst > 0 && n > 0) begin
				for (int k = 0; k < 4; k++) begin
					case ($urandom_range(0, 5))
						0: c[k] = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
						1: c[k] = 16'($urandom_range(0, 600)) - 16'd300;
						default: c[k] = 16'($urandom);
					endcase
				end
				send_request(c[0], c[1], c[2], c[3]);
				burst--;
				n--;
			end
			repeat ($urandom_range(0, 6)) hold_off();
		end
	endtask

	initial begin
		board = new();
		cycles = 0;
		stall_phase = 0;
		arst_n = 0;
		cfg_we = 0;
		cfg_wdata = 0;
		quat.valid = 0;
		quat.quat_x = 0;
		quat.quat_y = 0;
		quat.quat_z = 0;
		quat.quat_w = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);
		send_request(0, 0, 0, 16'h7fff);
		send_request(0, 0, 0, 16'h8000);
		send_request(0, 0, 16'h7fff, 0);
		send_request(16'h7fff, 0, 0, 0);
		send_request(0, 16'h7fff, 0, 0);
		send_request(16'h8000, 16'h8000, 16'h8000, 16'h8000);
		send_request(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
		send_request(16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
		send_request(0, 0, 0, 0);
		send_request(16'd5000, 16'd5000, 16'd23170, 16'd23170);
		send_request(16'd23170, 0, 0, 16'd23170);
		send_request(16'd23170, 0, 16'd23170, 0);
		send_request(16'd40, 16'd0, 16'd0, 16'd20);
		send_request(16'hffff, 16'h0001, 16'h0001, 16'hffff);
		send_request(16'd12000, 16'd100, 16'd9000, 16'd300);
		drain();
		write_tolerance(15'd0);
		send_request(0, 0, 0, 0);
		send_request(0, 0, 0, 16'd1);
		send_request(0, 0, 16'd1, 0);
		random_phase(200);
		drain();
		write_tolerance(15'h7fff);
		send_request(0, 0, 0, 16'h7fff);
		send_request(16'h8000, 16'h8000, 0, 0);
		random_phase(150);
		drain();
		write_tolerance(15'd20000);
		random_phase(150);
		drain();
		write_tolerance(15'h5555);
		random_phase(100);
		drain();
		write_tolerance(15'd2856);
		random_phase(230);
		drain();
		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
`default_nettype wire
